[rtl/nts_pkg.sv]
package nts_pkg;

  localparam int MAX_KEY_BYTES = 56;
  localparam int KEY_WORDS     = 7;
  localparam int KEY_WORD_W    = 64;
  localparam int BYTE_W        = 8;
  localparam int NIB_W         = 4;
  localparam int POS_W         = 6;
  localparam int WORD_SEL_W    = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int MODE_W        = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENCRYPT = 2'd0,
    MODE_DECRYPT = 2'd1,
    MODE_RECOVER = 2'd2,
    MODE_IGNORE  = 2'd3
  } mode_t;

  // Configuration register indexes; key word w sits at CFG_KEY_WORD_0 + w.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_6 = 4'd7;

  typedef logic [KEY_WORD_W-1:0] key_word_t;
  typedef key_word_t key_bank_t [KEY_WORDS];

  // Key schedule result handed to the substitution logic.
  typedef struct packed {
    logic [POS_W-1:0]  pos_used;
    logic [BYTE_W-1:0] key_byte;
  } key_sel_t;

  typedef logic [NIB_W-1:0] nib_t;

  localparam nib_t SQ [16][16] = '{
    '{4'h7,4'h5,4'h0,4'h4,4'h2,4'h3,4'hb,4'h6,4'ha,4'h8,4'h9,4'hd,4'hc,4'hf,4'he,4'h1},
    '{4'h3,4'h8,4'hd,4'ha,4'hc,4'he,4'hf,4'hb,4'h7,4'h6,4'h4,4'h5,4'h1,4'h2,4'h0,4'h9},
    '{4'h4,4'h0,4'h3,4'h1,4'hb,4'ha,4'h8,4'h5,4'h9,4'hd,4'hc,4'he,4'hf,4'h6,4'h7,4'h2},
    '{4'h9,4'he,4'h7,4'hc,4'h6,4'h4,4'h5,4'hd,4'h1,4'h0,4'h2,4'h3,4'hb,4'h8,4'ha,4'hf},
    '{4'h1,4'h3,4'ha,4'h2,4'h8,4'h9,4'hd,4'h0,4'hc,4'he,4'hf,4'h7,4'h6,4'h5,4'h4,4'hb},
    '{4'he,4'h6,4'h5,4'h7,4'h1,4'h0,4'h2,4'hf,4'h3,4'hb,4'ha,4'h8,4'h9,4'hc,4'hd,4'h4},
    '{4'h2,4'ha,4'h9,4'hb,4'hd,4'hc,4'he,4'h3,4'hf,4'h7,4'h6,4'h4,4'h5,4'h0,4'h1,4'h8},
    '{4'h6,4'h1,4'h2,4'h5,4'h3,4'hb,4'ha,4'h4,4'h8,4'h9,4'hd,4'hc,4'he,4'h7,4'hf,4'h0},
    '{4'hb,4'h9,4'hc,4'h8,4'he,4'hf,4'h7,4'ha,4'h6,4'h4,4'h5,4'h1,4'h0,4'h3,4'h2,4'hd},
    '{4'h0,4'hb,4'h8,4'h3,4'h9,4'hd,4'hc,4'h2,4'he,4'hf,4'h7,4'h6,4'h4,4'h1,4'h5,4'ha},
    '{4'h8,4'hc,4'hf,4'hd,4'h7,4'h6,4'h4,4'h9,4'h5,4'h1,4'h0,4'h2,4'h3,4'ha,4'hb,4'he},
    '{4'h5,4'h2,4'hb,4'h0,4'ha,4'h8,4'h9,4'h1,4'hd,4'hc,4'he,4'hf,4'h7,4'h4,4'h6,4'h3},
    '{4'hd,4'hf,4'h6,4'he,4'h4,4'h5,4'h1,4'hc,4'h0,4'h2,4'h3,4'hb,4'ha,4'h9,4'h8,4'h7},
    '{4'hc,4'h7,4'h4,4'hf,4'h5,4'h1,4'h0,4'he,4'h2,4'h3,4'hb,4'ha,4'h8,4'hd,4'h9,4'h6},
    '{4'ha,4'hd,4'he,4'h9,4'hf,4'h7,4'h6,4'h8,4'h4,4'h5,4'h1,4'h0,4'h2,4'hb,4'h3,4'hc},
    '{4'hf,4'h4,4'h1,4'h6,4'h0,4'h2,4'h3,4'h7,4'hb,4'ha,4'h8,4'h9,4'hd,4'he,4'hc,4'h5}
  };

  function automatic nib_t sq_fwd(nib_t row, nib_t col);
    return SQ[row][col];
  endfunction

  // Row holding v in the given column. The square is Latin, so exactly one matches.
  function automatic nib_t sq_find_row(nib_t v, nib_t col);
    nib_t res;
    res = '0;
    for (int r = 0; r < 16; r++) begin
      if (SQ[r][col] == v) res = nib_t'(r);
    end
    return res;
  endfunction

  function automatic nib_t sq_find_col(nib_t v, nib_t row);
    nib_t res;
    res = '0;
    for (int c = 0; c < 16; c++) begin
      if (SQ[row][c] == v) res = nib_t'(c);
    end
    return res;
  endfunction

endpackage

[rtl/nts_if.sv]
interface nts_in_if;
  logic                           valid;
  logic                           ready;
  logic [nts_pkg::MODE_W-1:0]     mode;
  logic [nts_pkg::BYTE_W-1:0]     data_byte;
  logic [nts_pkg::BYTE_W-1:0]     known_plain;
  logic                           restart;

  modport source (output valid, mode, data_byte, known_plain, restart, input ready);
  modport sink   (input valid, mode, data_byte, known_plain, restart, output ready);
endinterface

interface nts_out_if;
  logic                           valid;
  logic                           ready;
  logic [nts_pkg::BYTE_W-1:0]     result_byte;
  logic [nts_pkg::POS_W-1:0]      key_position_used;

  modport source (output valid, result_byte, key_position_used, input ready);
  modport sink   (input valid, result_byte, key_position_used, output ready);
endinterface

interface nts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nts_pkg::CFG_IDX_W-1:0]     index;
  logic [nts_pkg::KEY_WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/nts_cfg_regs.sv]
module nts_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  nts_cfg_if.sink                       cfg_bus,
  output logic [nts_pkg::POS_W-1:0]     key_len_eff,
  output nts_pkg::key_bank_t            key_words
);
  import nts_pkg::*;

  logic [POS_W-1:0] key_length_r;
  key_bank_t        key_words_r;
  logic             wr_en;

  assign cfg_bus.ready = 1'b1;
  assign wr_en         = cfg_bus.valid & cfg_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= POS_W'(1);
      for (int w = 0; w < KEY_WORDS; w++) key_words_r[w] <= '0;
    end else if (wr_en) begin
      if (cfg_bus.index == CFG_KEY_LENGTH) begin
        key_length_r <= cfg_bus.data[POS_W-1:0];
      end
      for (int w = 0; w < KEY_WORDS; w++) begin
        if (cfg_bus.index == CFG_KEY_WORD_0 + CFG_IDX_W'(w)) key_words_r[w] <= cfg_bus.data;
      end
    end
  end

  // A length of zero behaves as one; anything past the key store saturates.
  always_comb begin
    if (key_length_r == '0) begin
      key_len_eff = POS_W'(1);
    end else if (key_length_r > POS_W'(MAX_KEY_BYTES)) begin
      key_len_eff = POS_W'(MAX_KEY_BYTES);
    end else begin
      key_len_eff = key_length_r;
    end
  end

  assign key_words = key_words_r;

endmodule

[rtl/nts_key_sched.sv]
module nts_key_sched (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  nts_pkg::mode_t                mode,
  input  logic                          restart,
  input  logic [nts_pkg::POS_W-1:0]     key_len_eff,
  input  nts_pkg::key_bank_t            key_words,
  output nts_pkg::key_sel_t             key_sel
);
  import nts_pkg::*;

  logic [POS_W-1:0]      key_pos_r;
  logic [POS_W-1:0]      key_pos_nxt;
  logic [POS_W-1:0]      pos_base;
  logic [POS_W-1:0]      pos_wrapped;
  logic                  uses_key;
  key_word_t             sel_word;

  assign pos_base    = restart ? '0 : key_pos_r;
  // The wrap is applied lazily, just before the position is used.
  assign pos_wrapped = (pos_base >= key_len_eff) ? '0 : pos_base;
  assign uses_key    = (mode == MODE_ENCRYPT) || (mode == MODE_DECRYPT);

  assign sel_word         = key_words[pos_wrapped[POS_W-1:WORD_SEL_W]];
  assign key_sel.key_byte = sel_word[pos_wrapped[WORD_SEL_W-1:0]*BYTE_W +: BYTE_W];
  assign key_sel.pos_used = uses_key ? pos_wrapped : '0;
  assign key_pos_nxt      = uses_key ? pos_wrapped + POS_W'(1) : pos_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r <= '0;
    end else if (advance) begin
      key_pos_r <= key_pos_nxt;
    end
  end

endmodule

[rtl/nts_nibble_map.sv]
module nts_nibble_map (
  input  nts_pkg::mode_t                mode,
  input  logic [nts_pkg::BYTE_W-1:0]    data_byte,
  input  logic [nts_pkg::BYTE_W-1:0]    known_plain,
  input  logic [nts_pkg::BYTE_W-1:0]    key_byte,
  output logic [nts_pkg::BYTE_W-1:0]    result_byte
);
  import nts_pkg::*;

  nib_t dh, dl, kh, kl, ph, pl;

  assign dh = data_byte[BYTE_W-1:NIB_W];
  assign dl = data_byte[NIB_W-1:0];
  assign kh = key_byte[BYTE_W-1:NIB_W];
  assign kl = key_byte[NIB_W-1:0];
  assign ph = known_plain[BYTE_W-1:NIB_W];
  assign pl = known_plain[NIB_W-1:0];

  always_comb begin
    unique case (mode)
      MODE_ENCRYPT: result_byte = {sq_fwd(dh, kl), sq_fwd(dl, kh)};
      MODE_DECRYPT: result_byte = {sq_find_row(dh, kl), sq_find_row(dl, kh)};
      // The low cipher nibble was keyed by the high key nibble, and vice versa.
      MODE_RECOVER: result_byte = {sq_find_col(dl, pl), sq_find_col(dh, ph)};
      default:      result_byte = '0;
    endcase
  end

endmodule

[rtl/nibble_table_stream_cipher.sv]
// Channel  | Dir | Payload                                      | Handshake
// in_bus   | in  | mode, data_byte, known_plain, restart        | valid/ready
// out_bus  | out | result_byte, key_position_used               | valid/ready
// cfg_bus  | in  | index (0 key_length, 1..7 key words), data   | valid/ready
//
// One request per cycle sustained while out_bus is ready; a request accepted into the input
// register crosses the table logic and moves into the result register when it has room.
// The key position register is updated as a request moves from the input register
// to the result register, so consecutive requests see each other's position.
// Synchronous active-low reset empties both registers, zeroes the position and key words,
// and sets the key length to one.
// A stall on out_bus backs up through both registers; cfg_bus is always ready.
module nibble_table_stream_cipher (
  input  logic         clk,
  input  logic         rst_n,
  nts_in_if.sink       in_bus,
  nts_out_if.source    out_bus,
  nts_cfg_if.sink      cfg_bus
);
  import nts_pkg::*;

  logic                 a_valid_r;
  mode_t                a_mode_r;
  logic [BYTE_W-1:0]    a_data_r;
  logic [BYTE_W-1:0]    a_known_r;
  logic                 a_restart_r;

  logic                 o_valid_r;
  logic [BYTE_W-1:0]    o_result_r;
  logic [POS_W-1:0]     o_used_r;

  logic                 a_advance;
  logic                 in_take;
  logic [POS_W-1:0]     key_len_eff;
  key_bank_t            key_words;
  key_sel_t             key_sel;
  logic [BYTE_W-1:0]    result_byte;

  assign a_advance    = a_valid_r && (!o_valid_r || out_bus.ready);
  assign in_bus.ready = !a_valid_r || a_advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  nts_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_bus     (cfg_bus),
    .key_len_eff (key_len_eff),
    .key_words   (key_words)
  );

  nts_key_sched u_key (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (a_advance),
    .mode        (a_mode_r),
    .restart     (a_restart_r),
    .key_len_eff (key_len_eff),
    .key_words   (key_words),
    .key_sel     (key_sel)
  );

  nts_nibble_map u_map (
    .mode        (a_mode_r),
    .data_byte   (a_data_r),
    .known_plain (a_known_r),
    .key_byte    (key_sel.key_byte),
    .result_byte (result_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      a_valid_r <= in_bus.valid;
    end
    if (in_take) begin
      a_mode_r    <= mode_t'(in_bus.mode);
      a_data_r    <= in_bus.data_byte;
      a_known_r   <= in_bus.known_plain;
      a_restart_r <= in_bus.restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (!o_valid_r || out_bus.ready) begin
      o_valid_r <= a_valid_r;
    end
    if (a_advance) begin
      o_result_r <= result_byte;
      o_used_r   <= key_sel.pos_used;
    end
  end

  assign out_bus.valid             = o_valid_r;
  assign out_bus.result_byte       = o_result_r;
  assign out_bus.key_position_used = o_used_r;

endmodule

[tb/nibble_cipher_checker.sv]
module nibble_cipher_checker (
  input  logic clk,
  input  logic rst_n,
  nts_in_if    in_mon,
  nts_out_if   out_mon,
  nts_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import nts_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [POS_W-1:0]  pos;
  } cipher_out_t;

  // Latin square, one row per word, column 0 in the top nibble.
  localparam logic [63:0] LATIN_ROWS [16] = '{
    64'h750423b6a89dcfe1, 64'h38dacefb76451209, 64'h4031ba859dcef672, 64'h9e7c645d1023b8af,
    64'h13a289d0cef7654b, 64'he657102f3ba89cd4, 64'h2a9bdce3f7645018, 64'h61253ba489dce7f0,
    64'hb9c8ef7a6451032d, 64'h0b839dc2ef76415a, 64'h8cfd764951023abe, 64'h52b0a891dcef7463,
    64'hdf6e451c023ba987, 64'hc74f510e23ba8d96, 64'hade9f76845102b3c, 64'hf4160237ba89dec5
  };

  logic [POS_W-1:0]      key_pos;
  logic [POS_W-1:0]      key_len_reg;
  logic [KEY_WORD_W-1:0] key_bank [KEY_WORDS];
  cipher_out_t           due_results [$];
  int                    fails = 0;
  int                    reported = 0;

  function automatic logic [3:0] latin(input logic [3:0] r, input logic [3:0] c);
    return LATIN_ROWS[r][(15 - int'(c)) * 4 +: 4];
  endfunction

  // Descending scans leave the lowest matching index, as a first-match search would.
  function automatic logic [3:0] row_in_col(input logic [3:0] v, input logic [3:0] c);
    logic [3:0] hit;
    hit = '0;
    for (int r = 15; r >= 0; r--) begin
      if (latin(4'(r), c) == v) hit = 4'(r);
    end
    return hit;
  endfunction

  function automatic logic [3:0] col_in_row(input logic [3:0] v, input logic [3:0] r);
    logic [3:0] hit;
    hit = '0;
    for (int c = 15; c >= 0; c--) begin
      if (latin(r, 4'(c)) == v) hit = 4'(c);
    end
    return hit;
  endfunction

  // Works out the result of one request and steps the key position.
  function automatic cipher_out_t predict_cipher_out(input mode_t m, input logic [7:0] d,
                                                     input logic [7:0] kp, input logic rs);
    int          len;
    logic [7:0]  kb;
    cipher_out_t o;
    o = '0;
    if (rs) key_pos = '0;
    case (m) inside
      MODE_ENCRYPT, MODE_DECRYPT: begin
        len = int'(key_len_reg);
        if (len == 0) len = 1;
        if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
        // A position left beyond a shortened key wraps only when it is next used.
        if (int'(key_pos) >= len) key_pos = '0;
        o.pos = key_pos;
        kb = key_bank[key_pos[5:3]][int'(key_pos[2:0]) * 8 +: 8];
        if (m == MODE_ENCRYPT) begin
          o.byte_out = {latin(d[7:4], kb[3:0]), latin(d[3:0], kb[7:4])};
        end else begin
          o.byte_out = {row_in_col(d[7:4], kb[3:0]), row_in_col(d[3:0], kb[7:4])};
        end
        key_pos = key_pos + 1'b1;
      end
      MODE_RECOVER: begin
        o.byte_out = {col_in_row(d[3:0], kp[3:0]), col_in_row(d[7:4], kp[7:4])};
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    cipher_out_t want;
    cipher_out_t got;
    cipher_out_t next_due;
    if (!rst_n) begin
      key_pos = '0;
      key_len_reg = 6'd1;
      foreach (key_bank[w]) key_bank[w] = '0;
      due_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_KEY_LENGTH) begin
          key_len_reg = cfg_mon.data[POS_W-1:0];
        end else if (cfg_mon.index >= CFG_KEY_WORD_0 && cfg_mon.index <= CFG_KEY_WORD_6) begin
          key_bank[int'(cfg_mon.index - CFG_KEY_WORD_0)] = cfg_mon.data;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        next_due = predict_cipher_out(mode_t'(in_mon.mode), in_mon.data_byte,
                                      in_mon.known_plain, in_mon.restart);
        due_results = {due_results, next_due};
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.result_byte, out_mon.key_position_used};
        if (due_results.size() == 0) begin
          fails++;
          if (reported < 10) begin
            $display("%0t: unexpected result byte %02h pos %0d", $realtime,
                     got.byte_out, got.pos);
          end
          reported++;
        end else begin
          want = due_results.pop_front();
          if (want.byte_out !== got.byte_out || want.pos !== got.pos) begin
            fails++;
            if (reported < 10) begin
              $display("%0t: result mismatch: byte exp %02h got %02h, pos exp %0d got %0d",
                       $realtime, want.byte_out, got.byte_out, want.pos, got.pos);
            end
            reported++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= due_results.size();
  end

endmodule

[tb/tb_nibble_table_stream_cipher.sv]
module tb_nibble_table_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import nts_pkg::*;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY, RX_PERIODIC} rx_style_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 4'hF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int KEY_LEN_PLAN [8] = '{63, 56, 3, 1, 0, 17, 56, 2};

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  int        gap_max = 0;
  int        burst_left = 0;
  rx_style_t rx_style = RX_ALWAYS;

  nts_in_if  in_bus ();
  nts_out_if out_bus ();
  nts_cfg_if cfg_bus ();

  nibble_table_stream_cipher dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  nibble_cipher_checker cipher_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result receiver: the stall pattern changes from phase to phase.
  initial begin
    int   hold;
    int   rx_cycle;
    logic level;
    hold = 0;
    rx_cycle = 0;
    level = 1'b1;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      case (rx_style)
        RX_ALWAYS: out_bus.ready <= 1'b1;
        RX_RANDOM: out_bus.ready <= ($urandom_range(0, 9) < 7);
        RX_BURSTY: begin
          if (hold == 0) begin
            level = ~level;
            hold = level ? $urandom_range(1, 16) : $urandom_range(1, 12);
          end else begin
            hold--;
          end
          out_bus.ready <= level;
        end
        default: out_bus.ready <= ((rx_cycle % 7) != 3) && ((rx_cycle % 7) != 4);
      endcase
      rx_cycle++;
    end
  end

  // Valid stays high across back-to-back requests within a burst.
  task automatic send_req(input mode_t m, input logic [7:0] d, input logic [7:0] kp,
                          input logic rs);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= m;
    in_bus.data_byte   <= d;
    in_bus.known_plain <= kp;
    in_bus.restart     <= rs;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_WORD_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic end_cfg();
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    int               klen;
    int               eff_len;
    int               counted;
    int               msg_left;
    int               pick;
    logic             opening;
    logic             first_item;
    logic             rs;
    mode_t            m;
    mode_t            msg_mode;
    logic [KEY_WORD_W-1:0] wdata;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_ENCRYPT;
    in_bus.data_byte = '0;
    in_bus.known_plain = '0;
    in_bus.restart = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_KEY_LENGTH;
    cfg_bus.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: one key byte of zero.
    gap_max = 3;
    rx_style = RX_RANDOM;
    send_req(MODE_ENCRYPT, 8'h00, 8'h00, 1'b0);
    send_req(MODE_ENCRYPT, 8'hFF, 8'hFF, 1'b0);
    send_req(MODE_DECRYPT, 8'hFF, 8'h00, 1'b1);
    send_req(MODE_RECOVER, 8'h5A, 8'hC3, 1'b0);

    wait_idle();
    write_reg(CFG_KEY_LENGTH, 64'd5);
    write_reg(CFG_KEY_WORD_0, 64'h0000_5AA5_FF00_0FF0);
    write_reg(CFG_KEY_WORD_0 + 4'd1, '1);
    write_reg(CFG_KEY_WORD_0 + 4'd2, 64'h0123_4567_89AB_CDEF);
    for (int w = 3; w < KEY_WORDS; w++) begin
      write_reg(CFG_KEY_WORD_0 + 4'(w), {$urandom, $urandom});
    end
    // An index beyond the key words must change nothing.
    write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
    end_cfg();

    send_req(MODE_ENCRYPT, 8'h00, 8'h00, 1'b1);
    send_req(MODE_ENCRYPT, 8'hFF, 8'h00, 1'b0);
    send_req(MODE_DECRYPT, 8'h00, 8'hFF, 1'b0);
    send_req(MODE_DECRYPT, 8'hFF, 8'hFF, 1'b0);
    send_req(MODE_ENCRYPT, 8'h5A, 8'h00, 1'b0);
    send_req(MODE_ENCRYPT, 8'hA5, 8'h00, 1'b0);
    send_req(MODE_RECOVER, 8'hFF, 8'h00, 1'b0);
    send_req(MODE_RECOVER, 8'h00, 8'hFF, 1'b0);
    send_req(MODE_RECOVER, 8'h3C, 8'hC3, 1'b1);
    send_req(MODE_IGNORE, 8'hFF, 8'hFF, 1'b0);
    send_req(MODE_ENCRYPT, 8'h12, 8'h00, 1'b0);
    send_req(MODE_IGNORE, 8'h00, 8'h00, 1'b1);
    send_req(MODE_DECRYPT, 8'h34, 8'h00, 1'b0);
    send_req(MODE_ENCRYPT, 8'h56, 8'h00, 1'b0);

    // A key length of zero behaves as one; the upper data bits are not part of it.
    wait_idle();
    write_reg(CFG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0);
    end_cfg();
    send_req(MODE_ENCRYPT, 8'hFF, 8'h00, 1'b0);
    send_req(MODE_ENCRYPT, 8'h00, 8'h00, 1'b0);
    send_req(MODE_DECRYPT, 8'h80, 8'h00, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10);
      rx_style = rx_style_t'(p % 4);
      klen = (p < 8) ? KEY_LEN_PLAN[p] : $urandom_range(0, 63);
      wdata = {$urandom, $urandom};
      wdata[POS_W-1:0] = 6'(klen);
      write_reg(CFG_KEY_LENGTH, wdata);
      for (int w = 0; w < KEY_WORDS; w++) begin
        wdata = {$urandom, $urandom};
        if (p == 3) wdata = '1;
        if (p == 4) wdata = '0;
        write_reg(CFG_KEY_WORD_0 + 4'(w), wdata);
      end
      end_cfg();
      eff_len = (klen == 0) ? 1 : ((klen > MAX_KEY_BYTES) ? MAX_KEY_BYTES : klen);

      // Messages open with a restart, except the first one of a phase, which carries
      // on from the old position, and an occasional broken one.
      counted = 0;
      msg_left = 0;
      first_item = 1'b1;
      opening = 1'b0;
      msg_mode = MODE_ENCRYPT;
      while (counted < PHASE_ITEMS) begin
        if (msg_left == 0) begin
          msg_left = $urandom_range(1, 2 * eff_len + 4);
          if ($urandom_range(0, 1) == 1) msg_mode = MODE_DECRYPT;
          else msg_mode = MODE_ENCRYPT;
          opening = !first_item && ($urandom_range(0, 9) != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) m = msg_mode;
        else if (pick < 93) m = MODE_RECOVER;
        else m = MODE_IGNORE;
        rs = opening || ($urandom_range(0, 63) == 0);
        send_req(m, 8'($urandom), 8'($urandom), rs);
        opening = 1'b0;
        first_item = 1'b0;
        msg_left--;
        if (m != MODE_IGNORE) counted++;
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
